// ----- design/opqp_pkg.sv -----
package opqp_pkg;

    // Fixed field widths
    localparam int unsigned RATE_BITS     = 24;
    localparam int unsigned RADIUS_BITS   = 15;
    localparam int unsigned STEP_BITS     = 16;
    localparam int unsigned CFG_DATA_BITS = 24;
    localparam int unsigned CFG_ADDR_BITS = 1;

    // Angle and fraction format of the trig unit
    localparam int unsigned ANGLE_BITS = 32;
    localparam int unsigned Q_FRAC     = 30;
    localparam int unsigned TERMS      = 7;
    localparam int unsigned TERM_BITS  = 3;

    localparam logic [31:0] Q_ONE = 32'h4000_0000;
    // Fractional part of 2*pi*2^30 / 2^32 per 2^-32 turn (whole part is one)
    localparam logic [31:0] TWO_PI_FRAC = 32'd2451551556;

    // Register reset values
    localparam logic [RATE_BITS-1:0]   RATE_RESET   = 24'd33554;
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 15'd1;

    // Register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_PHASE_RATE = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_RADIUS     = 1'b1;

    // Item commands
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef logic [TERM_BITS-1:0] t_term;

    // Sine series divisor 2k(2k+1), k = 7 - term; first term unused
    function automatic logic [7:0] f_sin_div(t_term term);
        logic [7:0] d;
        case (term)
            3'd1:    d = 8'd156;
            3'd2:    d = 8'd110;
            3'd3:    d = 8'd72;
            3'd4:    d = 8'd42;
            3'd5:    d = 8'd20;
            default: d = 8'd6;
        endcase
        return d;
    endfunction

    // Cosine series divisor (2k-1)2k, k = 7 - term
    function automatic logic [7:0] f_cos_div(t_term term);
        logic [7:0] d;
        case (term)
            3'd0:    d = 8'd182;
            3'd1:    d = 8'd132;
            3'd2:    d = 8'd90;
            3'd3:    d = 8'd56;
            3'd4:    d = 8'd30;
            3'd5:    d = 8'd12;
            default: d = 8'd2;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor) for the sine divisors
    function automatic logic [31:0] f_sin_recip(t_term term);
        logic [31:0] m;
        case (term)
            3'd1:    m = 32'd27531841;
            3'd2:    m = 32'd39045157;
            3'd3:    m = 32'd59652323;
            3'd4:    m = 32'd102261126;
            3'd5:    m = 32'd214748364;
            default: m = 32'd715827882;
        endcase
        return m;
    endfunction

    // floor(2^32 / divisor) for the cosine divisors
    function automatic logic [31:0] f_cos_recip(t_term term);
        logic [31:0] m;
        case (term)
            3'd0:    m = 32'd23598721;
            3'd1:    m = 32'd32537631;
            3'd2:    m = 32'd47721858;
            3'd3:    m = 32'd76695844;
            3'd4:    m = 32'd143165576;
            3'd5:    m = 32'd357913941;
            default: m = 32'd2147483648;
        endcase
        return m;
    endfunction

endpackage

// ----- design/orbit_phase_quadrature_position.sv -----
// Orbit phase accumulator with quadrature position output. Each input
// transfer is one item: tuser = 0 advances the stored phase by
// (phase_rate * time_step) >> 16, wrapping modulo one turn; tuser = 1 loads
// new_phase. Every item yields one output transfer with radius*cos(phase),
// radius*sin(phase) (rounded half away from zero, clamped to
// +/-(2^(OUT_BITS-1)-1)) and the new phase. The phase lives in a single-entry
// memory that is read and then written back; sine and cosine come from a
// seven-term fixed-point series run on two multiplier lanes, each term in the
// steps TA, TB and TC. An item's input is taken only while the block is idle,
// so a new item is not accepted until the last result is loaded into the
// output register; a result waiting in the output register does not block the
// next input until that next result is ready. phase_rate (index 0) and radius
// (index 1) are to be written through the configuration port only while idle;
// the block itself does not enforce this.
module orbit_phase_quadrature_position #(
    parameter int unsigned PHASE_BITS = 24,
    parameter int unsigned OUT_BITS   = 16,
    localparam int unsigned IN_DATA_BITS  =
        ((opqp_pkg::STEP_BITS + PHASE_BITS + 7) / 8) * 8,
    localparam int unsigned OUT_DATA_BITS =
        ((2 * OUT_BITS + PHASE_BITS + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [opqp_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [opqp_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // time_step, new_phase (from bit 0 up), zero padded
    input  logic [IN_DATA_BITS-1:0]            s_axis_tdata,
    // cmd
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // pos_x, pos_y, phase_out (from bit 0 up), zero padded
    output logic [OUT_DATA_BITS-1:0]           m_axis_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PHASE,
        ST_TRIG,
        ST_OUT
    } t_state;

    t_state                           r_state;
    logic                             r_ph_start;
    logic                             r_trig_start;
    logic                             r_m_valid;
    logic [OUT_DATA_BITS-1:0]         r_m_data;
    logic                             r_cmd;
    logic [opqp_pkg::STEP_BITS-1:0]   r_time_step;
    logic [PHASE_BITS-1:0]            r_new_phase;
    logic [PHASE_BITS-1:0]            r_phase;
    logic [opqp_pkg::RATE_BITS-1:0]   r_phase_rate;
    logic [opqp_pkg::RADIUS_BITS-1:0] r_radius;

    logic                             w_ph_done;
    logic [PHASE_BITS-1:0]            w_ph_phase;
    logic                             w_trig_done;
    logic signed [OUT_BITS-1:0]       w_pos_x;
    logic signed [OUT_BITS-1:0]       w_pos_y;
    logic [opqp_pkg::ANGLE_BITS-1:0]  w_angle;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_rate <= opqp_pkg::RATE_RESET;
            r_radius     <= opqp_pkg::RADIUS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                opqp_pkg::CFG_PHASE_RATE: r_phase_rate <= i_cfg_data[opqp_pkg::RATE_BITS-1:0];
                opqp_pkg::CFG_RADIUS:     r_radius     <= i_cfg_data[opqp_pkg::RADIUS_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Item sequencing and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ph_start   <= 1'b0;
            r_trig_start <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            // Pulse the unit starts for one cycle
            r_ph_start   <= (r_state == ST_IDLE) && s_axis_tvalid;
            r_trig_start <= (r_state == ST_PHASE) && w_ph_done;
            // Drop the output once taken, unless a new result replaces it
            if (r_m_valid && m_axis_tready && (r_state != ST_OUT)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd       <= s_axis_tuser;
                        r_time_step <= s_axis_tdata[opqp_pkg::STEP_BITS-1:0];
                        r_new_phase <= s_axis_tdata[opqp_pkg::STEP_BITS +: PHASE_BITS];
                        r_state     <= ST_PHASE;
                    end
                end
                ST_PHASE: begin
                    if (w_ph_done) begin
                        r_phase <= w_ph_phase;
                        r_state <= ST_TRIG;
                    end
                end
                ST_TRIG: begin
                    if (w_trig_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // Load the result once the output register is free
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= OUT_DATA_BITS'({r_phase, w_pos_y, w_pos_x});
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // Phase memory with read-modify-write
    opqp_phase_store #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_ph_start),
        .i_cmd        (r_cmd),
        .i_time_step  (r_time_step),
        .i_new_phase  (r_new_phase),
        .i_phase_rate (r_phase_rate),
        .o_done       (w_ph_done),
        .o_phase      (w_ph_phase)
    );

    // Align phase to a 32-bit turn fraction
    assign w_angle = opqp_pkg::ANGLE_BITS'(r_phase) << (opqp_pkg::ANGLE_BITS - PHASE_BITS);

    opqp_trig #(
        .OUT_BITS (OUT_BITS)
    ) u_trig (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_trig_start),
        .i_angle  (w_angle),
        .i_radius (r_radius),
        .o_done   (w_trig_done),
        .o_pos_x  (w_pos_x),
        .o_pos_y  (w_pos_y)
    );

    a_ph_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ph_done |-> r_state == ST_PHASE)
        else $error("phase update finished outside phase step");

    a_trig_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_trig_done |-> r_state == ST_TRIG)
        else $error("trig result finished outside trig step");

    a_trig_after_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trig_start |-> $past(w_ph_done))
        else $error("trig started without a fresh phase");

endmodule

// ----- design/opqp_phase_store.sv -----
module opqp_phase_store #(
    parameter int unsigned PHASE_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_cmd,
    input  logic [opqp_pkg::STEP_BITS-1:0]   i_time_step,
    input  logic [PHASE_BITS-1:0]            i_new_phase,
    input  logic [opqp_pkg::RATE_BITS-1:0]   i_phase_rate,
    output logic                             o_done,
    output logic [PHASE_BITS-1:0]            o_phase
);

    localparam int unsigned PROD_BITS = opqp_pkg::RATE_BITS + opqp_pkg::STEP_BITS;
    localparam int unsigned SUM_BITS  =
        (PHASE_BITS > opqp_pkg::RATE_BITS) ? PHASE_BITS : opqp_pkg::RATE_BITS;

    // Single-entry phase memory with a registered read
    logic [PHASE_BITS-1:0]          r_mem [1];
    logic                           r_mem_vld;
    logic [PHASE_BITS-1:0]          r_rd_data;
    logic                           r_rd_vld;

    logic                           r_busy;
    logic                           r_done;
    logic [PHASE_BITS-1:0]          r_phase;
    logic                           r_cmd;
    logic [PHASE_BITS-1:0]          r_new_phase;
    logic [opqp_pkg::RATE_BITS-1:0] r_adv;

    logic [PROD_BITS-1:0]           w_prod;
    logic [PHASE_BITS-1:0]          w_old;
    logic [SUM_BITS-1:0]            w_sum;
    logic [PHASE_BITS-1:0]          w_wdata;

    // Advance = rate * step, scaled by 2^-16
    assign w_prod = PROD_BITS'(i_phase_rate) * PROD_BITS'(i_time_step);

    // Unwritten entry reads as the reset phase
    assign w_old   = r_rd_vld ? r_rd_data : '0;
    assign w_sum   = SUM_BITS'(w_old) + SUM_BITS'(r_adv);
    assign w_wdata = (r_cmd == opqp_pkg::CMD_LOAD) ? r_new_phase : w_sum[PHASE_BITS-1:0];

    // Memory read and write-back
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rd_data <= r_mem[0];
        end
        if (r_busy) begin
            r_mem[0] <= w_wdata;
        end
    end

    // Latch the item and the advance on start
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cmd       <= i_cmd;
            r_new_phase <= i_new_phase;
            r_adv       <= w_prod[PROD_BITS-1:opqp_pkg::STEP_BITS];
        end
        if (r_busy) begin
            r_phase <= w_wdata;
        end
    end

    // Sequence read then write; track the entry's valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
            r_mem_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
            if (i_start) begin
                r_rd_vld <= r_mem_vld;
            end
            if (r_busy) begin
                r_mem_vld <= 1'b1;
            end
        end
    end

    assign o_done  = r_done;
    assign o_phase = r_phase;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("phase update started while read-modify-write in flight");

    a_entry_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_mem_vld)
        else $error("phase reported before entry was written");

    a_entry_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_mem[0] == r_phase)
        else $error("stored phase differs from reported phase");

endmodule

// ----- design/opqp_trig.sv -----
module opqp_trig #(
    parameter int unsigned OUT_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [opqp_pkg::ANGLE_BITS-1:0]  i_angle,
    input  logic [opqp_pkg::RADIUS_BITS-1:0] i_radius,
    output logic                             o_done,
    output logic signed [OUT_BITS-1:0]       o_pos_x,
    output logic signed [OUT_BITS-1:0]       o_pos_y
);

    localparam int unsigned MAG_BITS   = 31;
    localparam int unsigned SCALE_BITS = opqp_pkg::RADIUS_BITS + MAG_BITS;
    localparam int unsigned RES_BITS   = SCALE_BITS + 1 - opqp_pkg::Q_FRAC;
    localparam int unsigned CMP_BITS   = (RES_BITS > OUT_BITS) ? RES_BITS : OUT_BITS;
    localparam logic [SCALE_BITS:0]  ROUND_HALF = (SCALE_BITS + 1)'(1) << (opqp_pkg::Q_FRAC - 1);
    localparam logic [OUT_BITS-1:0]  OUT_LIM    = {1'b0, {(OUT_BITS - 1){1'b1}}};
    localparam logic [OUT_BITS-1:0]  OUT_MIN    = {1'b1, {(OUT_BITS - 1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XMUL,
        ST_XADD,
        ST_SQ,
        ST_INIT,
        ST_TA,
        ST_TB,
        ST_TC,
        ST_SIN,
        ST_QUAD,
        ST_SCALE,
        ST_ROUND
    } t_state;

    t_state                  r_state;
    logic                    r_done;
    logic [1:0]              r_quad;
    logic [29:0]             r_r;
    logic [30:0]             r_x;
    logic [31:0]             r_x2;
    opqp_pkg::t_term         r_term;
    // Lane 0 carries the sine factor and x, lane 1 the cosine and y
    logic [31:0]             r_t    [2];
    logic [31:0]             r_a    [2];
    logic [63:0]             r_prod [2];
    logic [MAG_BITS-1:0]     r_mag  [2];
    logic                    r_neg  [2];
    logic [OUT_BITS-1:0]     r_pos  [2];

    logic [31:0]             w_ma   [2];
    logic [31:0]             w_mb   [2];
    logic [63:0]             w_mp   [2];
    logic [7:0]              w_d    [2];
    logic [31:0]             w_m    [2];
    logic [31:0]             w_q0   [2];
    logic [39:0]             w_qd   [2];
    logic [39:0]             w_rem  [2];
    logic [31:0]             w_q    [2];
    logic [31:0]             w_tn   [2];
    logic [SCALE_BITS:0]     w_rnd  [2];
    logic [RES_BITS-1:0]     w_res  [2];
    logic [OUT_BITS-1:0]     w_sat  [2];
    logic [OUT_BITS-1:0]     w_pos  [2];
    logic [MAG_BITS-1:0]     w_s_mag;
    logic [MAG_BITS-1:0]     w_c_mag;
    logic                    w_c_neg;
    logic [31:0]             w_c_abs;

    // Series constants for the current term
    assign w_d[0] = opqp_pkg::f_sin_div(r_term);
    assign w_d[1] = opqp_pkg::f_cos_div(r_term);
    assign w_m[0] = opqp_pkg::f_sin_recip(r_term);
    assign w_m[1] = opqp_pkg::f_cos_recip(r_term);

    // Select multiplier operands per step
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_ma[l] = '0;
            w_mb[l] = '0;
        end
        unique case (r_state)
            ST_XMUL: begin
                w_ma[0] = {2'b00, r_r};
                w_mb[0] = opqp_pkg::TWO_PI_FRAC;
            end
            ST_SQ: begin
                w_ma[0] = {1'b0, r_x};
                w_mb[0] = {1'b0, r_x};
            end
            ST_TA: begin
                for (int l = 0; l < 2; l++) begin
                    w_ma[l] = r_x2;
                    w_mb[l] = r_t[l];
                end
            end
            ST_TB: begin
                for (int l = 0; l < 2; l++) begin
                    w_ma[l] = r_prod[l][61:30];
                    w_mb[l] = w_m[l];
                end
            end
            ST_SIN: begin
                w_ma[0] = {1'b0, r_x};
                w_mb[0] = r_t[0];
            end
            ST_SCALE: begin
                for (int l = 0; l < 2; l++) begin
                    w_ma[l] = 32'(i_radius);
                    w_mb[l] = 32'(r_mag[l]);
                end
            end
            default: begin
            end
        endcase
    end

    // Two lane multipliers, each registered
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_mp[l] = 64'(w_ma[l]) * 64'(w_mb[l]);
        end
    end

    // Correct the reciprocal quotient and form the next factor
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_q0[l]  = r_prod[l][63:32];
            w_qd[l]  = 40'(w_q0[l]) * 40'(w_d[l]);
            w_rem[l] = 40'(r_a[l]) - w_qd[l];
            w_q[l]   = w_q0[l] + ((w_rem[l] >= 40'(w_d[l])) ? 32'd1 : 32'd0);
            w_tn[l]  = opqp_pkg::Q_ONE - w_q[l];
        end
    end

    // Magnitudes of sine and cosine
    assign w_s_mag = r_prod[0][60:30];
    assign w_c_neg = r_t[1][31];
    assign w_c_abs = 32'd0 - r_t[1];
    assign w_c_mag = w_c_neg ? w_c_abs[MAG_BITS-1:0] : r_t[1][MAG_BITS-1:0];

    // Round half away from zero, clamp, restore sign
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_rnd[l] = {1'b0, r_prod[l][SCALE_BITS-1:0]} + ROUND_HALF;
            w_res[l] = w_rnd[l][SCALE_BITS:opqp_pkg::Q_FRAC];
            w_sat[l] = (CMP_BITS'(w_res[l]) > CMP_BITS'(OUT_LIM)) ? OUT_LIM
                                                                   : OUT_BITS'(w_res[l]);
            w_pos[l] = r_neg[l] ? (OUT_BITS'(0) - w_sat[l]) : w_sat[l];
        end
    end

    // Step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == ST_ROUND);
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_quad  <= i_angle[31:30];
                        r_r     <= i_angle[29:0];
                        r_state <= ST_XMUL;
                    end
                end
                ST_XMUL: begin
                    r_prod[0] <= w_mp[0];
                    r_state   <= ST_XADD;
                end
                ST_XADD: begin
                    r_x     <= {1'b0, r_r} + {1'b0, r_prod[0][61:32]};
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    r_prod[0] <= w_mp[0];
                    r_state   <= ST_INIT;
                end
                ST_INIT: begin
                    r_x2    <= r_prod[0][61:30];
                    r_t[0]  <= opqp_pkg::Q_ONE;
                    r_t[1]  <= opqp_pkg::Q_ONE;
                    r_term  <= '0;
                    r_state <= ST_TA;
                end
                ST_TA: begin
                    for (int l = 0; l < 2; l++) begin
                        r_prod[l] <= w_mp[l];
                    end
                    r_state <= ST_TB;
                end
                ST_TB: begin
                    for (int l = 0; l < 2; l++) begin
                        r_prod[l] <= w_mp[l];
                        r_a[l]    <= r_prod[l][61:30];
                    end
                    r_state <= ST_TC;
                end
                ST_TC: begin
                    // Sine series has one term fewer: hold its factor on the first
                    if (r_term != '0) begin
                        r_t[0] <= w_tn[0];
                    end
                    r_t[1] <= w_tn[1];
                    if (r_term == opqp_pkg::t_term'(opqp_pkg::TERMS - 1)) begin
                        r_state <= ST_SIN;
                    end else begin
                        r_term  <= r_term + 1'b1;
                        r_state <= ST_TA;
                    end
                end
                ST_SIN: begin
                    r_prod[0] <= w_mp[0];
                    r_state   <= ST_QUAD;
                end
                ST_QUAD: begin
                    unique case (r_quad)
                        2'd0: begin
                            r_mag[0] <= w_c_mag;  r_neg[0] <= w_c_neg;
                            r_mag[1] <= w_s_mag;  r_neg[1] <= 1'b0;
                        end
                        2'd1: begin
                            r_mag[0] <= w_s_mag;  r_neg[0] <= 1'b1;
                            r_mag[1] <= w_c_mag;  r_neg[1] <= w_c_neg;
                        end
                        2'd2: begin
                            r_mag[0] <= w_c_mag;  r_neg[0] <= !w_c_neg;
                            r_mag[1] <= w_s_mag;  r_neg[1] <= 1'b1;
                        end
                        default: begin
                            r_mag[0] <= w_s_mag;  r_neg[0] <= 1'b0;
                            r_mag[1] <= w_c_mag;  r_neg[1] <= !w_c_neg;
                        end
                    endcase
                    r_state <= ST_SCALE;
                end
                ST_SCALE: begin
                    for (int l = 0; l < 2; l++) begin
                        r_prod[l] <= w_mp[l];
                    end
                    r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    for (int l = 0; l < 2; l++) begin
                        r_pos[l] <= w_pos[l];
                    end
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_pos_x = $signed(r_pos[0]);
    assign o_pos_y = $signed(r_pos[1]);

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == ST_IDLE)
        else $error("trig unit started while busy");

    a_sine_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_QUAD |-> !r_t[0][31])
        else $error("sine series factor went negative");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_pos[0] != OUT_MIN) && (r_pos[1] != OUT_MIN))
        else $error("coordinate outside symmetric range");

endmodule

// ----- tb/orbit_phase_quadrature_position_checker.sv -----
// Watches the configuration port and both stream channels, keeps its own copy
// of the phase and the two registers, computes the expected position for every
// input transfer and compares each output transfer with the oldest expectation.
module orbit_phase_quadrature_position_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [opqp_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [opqp_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    // time_step, new_phase (from bit 0 up)
    input  logic [39:0]                        i_in_data,
    // cmd
    input  logic                               i_in_user,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    // pos_x, pos_y, phase_out (from bit 0 up)
    input  logic [55:0]                        i_out_data,
    output int                                 o_pending,
    output int                                 o_fail_count
);

    localparam logic [23:0] RATE_INIT   = 24'd33554;
    localparam logic [14:0] RADIUS_INIT = 15'd1;
    localparam longint      ONE_Q30     = longint'(1) << 30;
    localparam longint      COORD_MAX   = 32767;

    // One position result, last field in the lowest bits
    typedef struct packed {
        logic [23:0]        ph;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_orbit_pos;

    t_orbit_pos  expected_pos[$];
    t_orbit_pos  got;
    t_orbit_pos  want;
    logic [23:0] rate_q;
    logic [14:0] radius_q;
    logic [23:0] phase_q;
    int          n_fail;

    // Scale a Q30 coordinate by the radius, round half away from zero, clamp
    function automatic logic [15:0] scale_coord(input longint v, input logic [14:0] rad);
        logic   neg;
        longint mag;
        longint res;
        neg = (v < 0);
        mag = neg ? -v : v;
        res = (longint'(rad) * mag + ONE_Q30 / 2) / ONE_Q30;
        if (res > COORD_MAX)
            res = COORD_MAX;
        if (neg)
            res = -res;
        return res[15:0];
    endfunction

    // Position on the orbit for a phase: series sine and cosine per quadrant
    function automatic t_orbit_pos orbit_point(input logic [23:0] ph,
                                               input logic [14:0] rad);
        logic [31:0] turn;
        logic [63:0] prod;
        longint      x;
        longint      x2;
        longint      t;
        longint      s;
        longint      c;
        longint      cx;
        longint      sy;
        t_orbit_pos  pos;
        turn = {ph, 8'h00};
        prod = 64'(turn[29:0]) * 64'd6746518852;
        x    = longint'(prod >> 32);
        x2   = (x * x) / ONE_Q30;
        t    = ONE_Q30;
        for (int k = 6; k >= 1; k--)
            t = ONE_Q30 - ((x2 * t) / ONE_Q30) / longint'((2 * k) * (2 * k + 1));
        s = (x * t) / ONE_Q30;
        t = ONE_Q30;
        for (int k = 7; k >= 1; k--)
            t = ONE_Q30 - ((x2 * t) / ONE_Q30) / longint'((2 * k - 1) * (2 * k));
        c = t;
        case (turn[31:30])
            2'd0:    begin cx = c;  sy = s;  end
            2'd1:    begin cx = -s; sy = c;  end
            2'd2:    begin cx = -c; sy = -s; end
            default: begin cx = s;  sy = -c; end
        endcase
        pos.x  = scale_coord(cx, rad);
        pos.y  = scale_coord(sy, rad);
        pos.ph = ph;
        return pos;
    endfunction

    // Track registers, predict on input transfers, compare on output transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rate_q   = RATE_INIT;
            radius_q = RADIUS_INIT;
            phase_q  = '0;
            n_fail   = 0;
            expected_pos.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == opqp_pkg::CFG_PHASE_RATE)
                    rate_q = i_cfg_data[23:0];
                else if (i_cfg_addr == opqp_pkg::CFG_RADIUS)
                    radius_q = i_cfg_data[14:0];
            end

            if (i_in_valid && i_in_ready) begin
                if (i_in_user == opqp_pkg::CMD_TICK)
                    phase_q = phase_q + 24'((64'(rate_q) * 64'(i_in_data[15:0])) >> 16);
                else
                    phase_q = i_in_data[39:16];
                expected_pos.push_back(orbit_point(phase_q, radius_q));
            end

            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (expected_pos.size() == 0) begin
                    if (n_fail < 10)
                        $display("unexpected result: x=%0d y=%0d phase=%h",
                                 got.x, got.y, got.ph);
                    n_fail++;
                end else begin
                    want = expected_pos.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.ph !== want.ph) begin
                        if (n_fail < 10)
                            $display({"mismatch: expected x=%0d y=%0d phase=%h, ",
                                      "got x=%0d y=%0d phase=%h"},
                                     want.x, want.y, want.ph, got.x, got.y, got.ph);
                        n_fail++;
                    end
                end
            end
        end
        o_pending    <= expected_pos.size();
        o_fail_count <= n_fail;
    end

endmodule

// ----- tb/orbit_phase_quadrature_position_tb.sv -----
module orbit_phase_quadrature_position_tb;

    localparam int IN_BITS  = 40;
    localparam int OUT_BITS = 56;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [opqp_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr;
    logic [opqp_pkg::CFG_DATA_BITS-1:0] i_cfg_data;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    // time_step, new_phase (from bit 0 up)
    logic [IN_BITS-1:0]                 s_axis_tdata;
    // cmd
    logic                               s_axis_tuser;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    // pos_x, pos_y, phase_out (from bit 0 up)
    logic [OUT_BITS-1:0]                m_axis_tdata;

    int pending;
    int fail_count;
    int send_idle  = 0;
    int recv_stall = 0;

    always #5 i_clk = ~i_clk;

    orbit_phase_quadrature_position u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    orbit_phase_quadrature_position_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Stall the result side at the rate of the current phase
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    // Offer one item, idling first at random, and hold it until the transfer
    task automatic send_item(input logic cmd, input logic [15:0] step,
                             input logic [23:0] ph);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {ph, step};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // Drop valid and hold until every expected result has been taken
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both registers back to back
    task automatic set_orbit(input logic [23:0] rate, input logic [23:0] rad);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= opqp_pkg::CFG_PHASE_RATE;
        i_cfg_data <= rate;
        @(posedge i_clk);
        i_cfg_addr <= opqp_pkg::CFG_RADIUS;
        i_cfg_data <= rad;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [23:0] rate;
        logic [23:0] rad;
        logic [15:0] step;
        int          mode;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= opqp_pkg::CMD_TICK;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items at reset settings: step extremes and quadrant loads
        send_item(opqp_pkg::CMD_TICK, 16'h0000, 24'hFFFFFF);
        send_item(opqp_pkg::CMD_TICK, 16'hFFFF, 24'h000000);
        send_item(opqp_pkg::CMD_TICK, 16'h0001, 24'h5A5A5A);
        send_item(opqp_pkg::CMD_LOAD, 16'hFFFF, 24'h000000);
        send_item(opqp_pkg::CMD_LOAD, 16'h0000, 24'hFFFFFF);
        send_item(opqp_pkg::CMD_LOAD, 16'h1234, 24'h400000);
        send_item(opqp_pkg::CMD_LOAD, 16'h0000, 24'h800000);
        send_item(opqp_pkg::CMD_LOAD, 16'h0000, 24'hC00000);
        wait_idle();

        // Full rate and full radius, the latter written with excess high bits
        set_orbit(24'hFFFFFF, 24'hFFFFFF);
        send_item(opqp_pkg::CMD_LOAD, 16'h0000, 24'h3FFFFF);
        send_item(opqp_pkg::CMD_LOAD, 16'h0000, 24'h7FFFFF);
        send_item(opqp_pkg::CMD_LOAD, 16'h0000, 24'hBFFFFF);
        send_item(opqp_pkg::CMD_LOAD, 16'h0000, 24'h200000);
        send_item(opqp_pkg::CMD_LOAD, 16'h0000, 24'hA00000);
        send_item(opqp_pkg::CMD_LOAD, 16'h0000, 24'h000000);
        send_item(opqp_pkg::CMD_LOAD, 16'h0000, 24'hFFFF00);
        // Phase wraps past one turn
        send_item(opqp_pkg::CMD_TICK, 16'hFFFF, 24'hFFFFFF);
        send_item(opqp_pkg::CMD_TICK, 16'hFFFF, 24'h000000);
        send_item(opqp_pkg::CMD_TICK, 16'h8000, 24'hABCDEF);
        send_item(opqp_pkg::CMD_TICK, 16'h0001, 24'h000000);
        wait_idle();

        // Random phases over settings and idling modes
        for (int stage = 0; stage < 8; stage++) begin
            mode       = stage % 4;
            send_idle  = (mode == 1) ? 85 : (mode == 3) ? 29 : 0;
            recv_stall = (mode == 2) ? 85 : (mode == 3) ? 29 : 0;
            case (stage)
                0:       begin rate = 24'h000000; rad = 24'h000000; end
                1:       begin rate = 24'hFFFFFF; rad = 24'h007FFF; end
                3:       begin rate = 24'd33554;  rad = 24'h000001; end
                4:       begin rate = 24'($urandom_range(4095)); rad = 24'h007FFF; end
                6:       begin rate = 24'($urandom); rad = 24'h008000 | 24'($urandom_range(32767)); end
                default: begin rate = 24'($urandom); rad = 24'($urandom); end
            endcase
            set_orbit(rate, rad);
            for (int n = 0; n < 60; n++) begin
                if (stage == 1 && n == 30)
                    wait_idle();
                step = ($urandom_range(3) == 0) ? 16'($urandom_range(15)) : 16'($urandom);
                if ($urandom_range(9) < 3)
                    send_item(opqp_pkg::CMD_LOAD, step, 24'($urandom));
                else
                    send_item(opqp_pkg::CMD_TICK, step, 24'($urandom));
            end
            wait_idle();
        end

        // Drain and watch for stray results
        send_idle  = 0;
        recv_stall = 0;
        wait_idle();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Stop a hung run
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
design/opqp_pkg.sv
design/opqp_phase_store.sv
design/opqp_trig.sv
design/orbit_phase_quadrature_position.sv
tb/orbit_phase_quadrature_position_checker.sv
tb/orbit_phase_quadrature_position_tb.sv
